FILE: src/abr_pkg.sv
// Shared types and constants for the alternating-bit receiver.
package abr_pkg;

  // ASCII codes used for frame bits and reply flags.
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;

  // Frame byte plus check byte.
  localparam int HEADER_BYTES = 2;

  // Smallest buffer size that the block will use.
  localparam int MIN_BUFFER_BYTES = 3;

  // Width of the buffer size register.
  localparam int CFG_W = 11;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // What a received byte is, as decided by the front part.
  typedef enum logic [1:0] {
    KIND_FRAME,
    KIND_CHECK,
    KIND_PAYLOAD,
    KIND_IGNORE
  } byte_kind_t;

  // One classified byte, passed from the front part to the back part.
  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data;
    logic        last;
    logic        too_short;
    logic        header_only;
  } abr_item_t;

  // One result item.
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        packet_end;
    logic        accept;
    logic        reply_valid;
    logic [7:0]  reply_frame;
    logic [7:0]  reply_flag;
    logic        transfer_done;
  } abr_result_t;

endpackage

FILE: src/abr_front.sv
// Front part: holds the buffer size, tracks the byte position and classifies each byte.
module abr_front #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [abr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_take,
  input  logic [7:0]               rx_byte,
  input  logic                     rx_last,
  output abr_pkg::abr_item_t       item
);
  import abr_pkg::*;

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  logic [CFG_W-1:0] buffer_bytes;
  logic [PW-1:0]    byte_position;
  logic [PW-1:0]    byte_position_next;
  logic [CW-1:0]    buf_raw;
  logic [CW-1:0]    buf_eff;
  logic [CW-1:0]    pos_wide;
  logic             in_buffer;
  logic [PW-1:0]    count;

  // Buffer size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= CFG_W'(1024);
    end else if (cfg_we) begin
      buffer_bytes <= cfg_wdata;
    end
  end

  // Clamp the buffer size to the supported range.
  always_comb begin
    buf_raw = CW'(buffer_bytes);
    if (buf_raw < CW'(MIN_BUFFER_BYTES)) begin
      buf_eff = CW'(MIN_BUFFER_BYTES);
    end else if (buf_raw > CW'(MAX_PACKET_BYTES)) begin
      buf_eff = CW'(MAX_PACKET_BYTES);
    end else begin
      buf_eff = buf_raw;
    end
  end

  // Classify the incoming byte by its position in the packet.
  always_comb begin
    pos_wide  = CW'(byte_position);
    in_buffer = pos_wide < buf_eff;
    count     = in_buffer ? byte_position + PW'(1) : byte_position;

    item.data        = rx_byte;
    item.last        = rx_last;
    item.too_short   = count < PW'(HEADER_BYTES);
    item.header_only = count == PW'(HEADER_BYTES);
    if (!in_buffer) begin
      item.kind = KIND_IGNORE;
    end else if (byte_position == PW'(0)) begin
      item.kind = KIND_FRAME;
    end else if (byte_position == PW'(1)) begin
      item.kind = KIND_CHECK;
    end else begin
      item.kind = KIND_PAYLOAD;
    end

    byte_position_next = rx_last ? PW'(0) : count;
  end

  // Byte position is updated on every accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (in_take) begin
      byte_position <= byte_position_next;
    end
  end

endmodule

FILE: src/abr_queue.sv
// Short queue of classified bytes between the front and back parts.
module abr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  abr_pkg::abr_item_t push_item,
  output logic               full,
  input  logic               pop,
  output abr_pkg::abr_item_t pop_item,
  output logic               empty
);
  import abr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  abr_item_t       entries [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == NW'(QUEUE_DEPTH);
  assign empty    = count == NW'(0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

FILE: src/abr_back.sv
// Back part: keeps the header and running XOR, gives verdicts and holds the result register.
module abr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  abr_pkg::abr_item_t   q_item,
  output logic                 q_pop,
  output abr_pkg::abr_result_t result,
  output logic                 empty,
  input  logic                 pop
);
  import abr_pkg::*;

  logic        expected_bit;
  logic [7:0]  running_xor;
  logic [7:0]  frame_byte;
  logic [7:0]  check_byte;
  logic        out_valid;

  logic [7:0]  frame_cur;
  logic [7:0]  check_cur;
  logic [7:0]  xor_cur;
  logic [7:0]  exp_char;
  logic        frame_ok;
  logic        xor_ok;
  abr_result_t result_next;
  logic        expected_bit_next;

  // Take the next byte whenever the result register is free or being drained.
  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  // Fold the current byte into the header and XOR, then decide at packet end.
  always_comb begin
    frame_cur   = frame_byte;
    check_cur   = check_byte;
    xor_cur     = running_xor;
    result_next = '0;

    unique case (q_item.kind)
      KIND_FRAME:   frame_cur = q_item.data;
      KIND_CHECK:   check_cur = q_item.data;
      KIND_PAYLOAD: begin
        xor_cur                = running_xor ^ q_item.data;
        result_next.data_valid = 1'b1;
        result_next.data_byte  = q_item.data;
      end
      KIND_IGNORE:  ;
      default:      ;
    endcase

    exp_char          = expected_bit ? ASCII_ONE : ASCII_ZERO;
    frame_ok          = frame_cur == exp_char;
    xor_ok            = check_cur == xor_cur;
    expected_bit_next = expected_bit;

    if (q_item.last) begin
      result_next.packet_end = 1'b1;
      if (!q_item.too_short) begin
        result_next.reply_valid   = 1'b1;
        result_next.transfer_done = q_item.header_only;
        if (frame_ok && xor_ok) begin
          result_next.accept      = 1'b1;
          expected_bit_next       = !expected_bit;
          result_next.reply_frame = expected_bit ? ASCII_ZERO : ASCII_ONE;
          result_next.reply_flag  = ASCII_ZERO;
        end else if (frame_ok) begin
          result_next.reply_frame = frame_cur;
          result_next.reply_flag  = ASCII_ONE;
        end else begin
          result_next.reply_frame = exp_char;
          result_next.reply_flag  = ASCII_ZERO;
        end
      end
    end
  end

  // Packet state; the header and running XOR are cleared at every packet end.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bit <= 1'b0;
      running_xor  <= '0;
      frame_byte   <= '0;
      check_byte   <= '0;
    end else if (q_pop) begin
      expected_bit <= expected_bit_next;
      if (q_item.last) begin
        running_xor <= '0;
        frame_byte  <= '0;
        check_byte  <= '0;
      end else begin
        running_xor <= xor_cur;
        frame_byte  <= frame_cur;
        check_byte  <= check_cur;
      end
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= result_next;
    end
  end

  // A verdict or reply only appears on a packet's last byte.
  a_accept_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.accept) |-> (result.packet_end && result.reply_valid))
    else $error("accept without packet end");

  // A finished transfer always carries a reply.
  a_done_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.transfer_done) |-> result.reply_valid)
    else $error("transfer done without reply");

  // The expected bit only flips when a packet is accepted.
  a_toggle: assert property (@(posedge clk) disable iff (rst)
    (expected_bit != $past(expected_bit)) |-> (out_valid && result.accept))
    else $error("expected bit changed without an accepted packet");

endmodule

FILE: src/alternating_bit_receiver_core.sv
// Top level of the alternating-bit receiver.
// Stop-and-wait receiver that takes one packet byte per transfer (frame bit, XOR check byte,
// then payload) and gives exactly one result per byte: payload bytes are forwarded at once as
// tentative data, and the last byte of a packet carries the packet-end mark and, unless the
// packet is shorter than the header, the verdict, the two-byte reply and the end-of-transfer
// mark for a header-only packet. The block sustains one byte per clock cycle on both sides as
// long as the result side keeps popping. Each byte passes through the queue and the result
// register on its way out; a four-entry queue between the two parts absorbs stalls on the
// result side. The buffer size register may be written only while no packet is in flight.
module alternating_bit_receiver_core #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [abr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                rx_byte,
  input  logic                      rx_last,
  output logic                      empty,
  input  logic                      pop,
  output logic                      data_valid,
  output logic [7:0]                data_byte,
  output logic                      packet_end,
  output logic                      accept,
  output logic                      reply_valid,
  output logic [7:0]                reply_frame,
  output logic [7:0]                reply_flag,
  output logic                      transfer_done
);
  import abr_pkg::*;

  abr_item_t   front_item;
  abr_item_t   q_item;
  abr_result_t result;
  logic        in_take;
  logic        q_empty;
  logic        q_pop;

  assign in_take = push && !full;

  // Front part: classifies each byte as it is accepted.
  abr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_take   (in_take),
    .rx_byte   (rx_byte),
    .rx_last   (rx_last),
    .item      (front_item)
  );

  // Queue between the two parts.
  abr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // Back part: verdicts and result register.
  abr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  // Unpack the result onto its ports.
  assign data_valid    = result.data_valid;
  assign data_byte     = result.data_byte;
  assign packet_end    = result.packet_end;
  assign accept        = result.accept;
  assign reply_valid   = result.reply_valid;
  assign reply_frame   = result.reply_frame;
  assign reply_flag    = result.reply_flag;
  assign transfer_done = result.transfer_done;

endmodule
